// ===== src/clcd_pkg.sv =====
// Shared types, constants and tables for the character-LCD command sequencer.
// No dependencies; used by every module in src.
package clcd_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_W);
  localparam int unsigned PTR_W      = $clog2(NUM_DIGITS);
  localparam int unsigned WAIT_W     = 5;

  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_CURSOR = 3'd1;
  localparam logic [2:0] OP_CHAR   = 3'd2;
  localparam logic [2:0] OP_INT    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [7:0] BYTE_CLEAR   = 8'h01;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] SET_DDRAM    = 8'h80;
  localparam logic [2:0] INIT_LAST    = 3'd6;
  localparam logic [2:0] MAX_ROW      = 3'd3;
  localparam logic [4:0] MAX_COLUMN   = 5'd19;

  localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(NUM_DIGITS - 1);

  // One byte bound for the panel, split into two strobes by the emitter
  typedef struct packed {
    logic              rs;
    logic [7:0]        data;
    logic [WAIT_W-1:0] wait_ms;
    logic              last;
  } clcd_byte_t;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] clcd_bcd_t;

  // Power-up sequence: two wake-up bytes, then function set, display setup
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h03;
      3'd1:    b = 8'h03;
      3'd2:    b = 8'h02;
      3'd3:    b = 8'h28;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h0C;
      3'd6:    b = 8'h06;
      default: b = 8'h06;
    endcase
    return b;
  endfunction

  function automatic logic [WAIT_W-1:0] init_wait(input logic [2:0] idx);
    logic [WAIT_W-1:0] w;
    case (idx)
      3'd0:    w = WAIT_W'(16);
      3'd1:    w = WAIT_W'(5);
      3'd2:    w = WAIT_W'(1);
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [6:0] row_base(input logic [1:0] row);
    logic [6:0] b;
    case (row)
      2'd0:    b = 7'h00;
      2'd1:    b = 7'h40;
      2'd2:    b = 7'h14;
      2'd3:    b = 7'h54;
      default: b = 7'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/clcd_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on clcd_pkg.
module clcd_dabble (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [clcd_pkg::VALUE_W-1:0]    value_i,
  output logic                            busy_o,
  output clcd_pkg::clcd_bcd_t             bcd_o
);

  logic [clcd_pkg::VALUE_W-1:0]   bin_q;
  clcd_pkg::clcd_bcd_t            bcd_q, adj;
  logic [clcd_pkg::NUM_DIGITS*clcd_pkg::DIGIT_W-1:0] adj_flat;
  logic [clcd_pkg::BIT_CNT_W-1:0] cnt_q;
  logic                           busy_q;

  // Digits at 5 or above get 3 added before the shift
  always_comb begin
    for (int k = 0; k < clcd_pkg::NUM_DIGITS; k++) begin
      adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
    end
  end

  assign adj_flat = adj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[clcd_pkg::VALUE_W-2:0], 1'b0};
      bcd_q <= {adj_flat[clcd_pkg::NUM_DIGITS*clcd_pkg::DIGIT_W-2:0],
                bin_q[clcd_pkg::VALUE_W-1]};
    end
  end

  assign busy_o = busy_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== src/clcd_emit.sv =====
// Output stage: holds one byte and hands it out as two nibble items, high first.
// Depends on clcd_pkg.
module clcd_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  output logic                 byte_ready_o,
  input  clcd_pkg::clcd_byte_t byte_i,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast
);

  clcd_pkg::clcd_byte_t            hold_q;
  logic                            full_q, low_q;
  logic                            load;
  logic [3:0]                      nib;
  logic [clcd_pkg::WAIT_W-1:0]     wait_sel;

  assign byte_ready_o = !full_q || (m_axis_tready && low_q);
  assign load         = byte_valid_i && byte_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      low_q  <= 1'b0;
    end else if (load) begin
      full_q <= 1'b1;
      low_q  <= 1'b0;
    end else if (full_q && m_axis_tready) begin
      if (low_q) begin
        full_q <= 1'b0;
      end else begin
        low_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hold_q <= byte_i;
    end
  end

  assign nib      = low_q ? hold_q.data[3:0] : hold_q.data[7:4];
  assign wait_sel = low_q ? '0 : hold_q.wait_ms;

  assign m_axis_tvalid = full_q;
  assign m_axis_tdata  = {7'd0, wait_sel, nib};
  assign m_axis_tuser  = hold_q.rs;
  assign m_axis_tlast  = low_q && hold_q.last;

endmodule

// ===== src/char_lcd_4bit_command_sequencer.sv =====
// Character-LCD 4-bit command sequencer: one command item in, a run of nibble
// strobes out. Depends on clcd_pkg, clcd_dabble and clcd_emit.
// A taken command sets the state register, and each byte of the run is then
// loaded into the output stage's hold register, which drives the strobes. Print
// integer first runs bit-serial BCD conversion, then skips up to 8 leading zeros.
// Throughput: one command at a time; two strobes per byte, so a run has up to
// 20 strobes; print integer also waits for the conversion above.
// Reset (rst_ni low, asynchronous) empties the sequencer and output stage.
module char_lcd_4bit_command_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata: opcode[2:0], row[5:3], column[10:6], value[42:11], zero pad
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // m_axis_tdata: nibble[3:0], wait_before_ms[8:4], zero pad
  // m_axis_tuser: register_select; m_axis_tlast: last strobe of the run
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [2:0]                        opc_q;
  logic [2:0]                        row_q;
  logic [4:0]                        col_q;
  logic [7:0]                        char_q;
  logic [2:0]                        cnt_q;
  logic [clcd_pkg::PTR_W-1:0]        ptr_q;

  logic [2:0]                        in_opc, in_row;
  logic [4:0]                        in_col;
  logic [clcd_pkg::VALUE_W-1:0]      in_value;
  logic                              take, produces;

  logic                              conv_busy;
  clcd_pkg::clcd_bcd_t               bcd;
  logic [clcd_pkg::DIGIT_W-1:0]      cur_digit;

  clcd_pkg::clcd_byte_t              byte_d;
  logic                              byte_valid, byte_ready, byte_take;
  logic [6:0]                        ddram_addr;

  // Unpack the command item
  assign in_opc   = s_axis_tdata[2:0];
  assign in_row   = s_axis_tdata[5:3];
  assign in_col   = s_axis_tdata[10:6];
  assign in_value = s_axis_tdata[42:11];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign take          = s_axis_tvalid && s_axis_tready;

  // Out-of-range cursor and unknown opcodes are swallowed without output
  always_comb begin
    case (in_opc)
      clcd_pkg::OP_INIT,
      clcd_pkg::OP_CHAR,
      clcd_pkg::OP_INT,
      clcd_pkg::OP_CLEAR:  produces = 1'b1;
      clcd_pkg::OP_CURSOR: produces = (in_row <= clcd_pkg::MAX_ROW) &&
                                      (in_col <= clcd_pkg::MAX_COLUMN);
      default:             produces = 1'b0;
    endcase
  end

  clcd_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (take && (in_opc == clcd_pkg::OP_INT)),
    .value_i (in_value),
    .busy_o  (conv_busy),
    .bcd_o   (bcd)
  );

  assign cur_digit  = bcd[ptr_q];
  assign ddram_addr = clcd_pkg::row_base(row_q[1:0]) + {2'b00, col_q};

  // Byte for the current step of the run
  always_comb begin
    byte_d.rs      = 1'b0;
    byte_d.data    = clcd_pkg::BYTE_CLEAR;
    byte_d.wait_ms = '0;
    byte_d.last    = 1'b1;
    case (opc_q)
      clcd_pkg::OP_INIT: begin
        byte_d.data    = clcd_pkg::init_byte(cnt_q);
        byte_d.wait_ms = clcd_pkg::init_wait(cnt_q);
        byte_d.last    = (cnt_q == clcd_pkg::INIT_LAST);
      end
      clcd_pkg::OP_CURSOR: begin
        byte_d.data = clcd_pkg::SET_DDRAM | {1'b0, ddram_addr};
      end
      clcd_pkg::OP_CHAR: begin
        byte_d.rs   = 1'b1;
        byte_d.data = char_q;
      end
      clcd_pkg::OP_INT: begin
        byte_d.rs   = 1'b1;
        byte_d.data = clcd_pkg::ASCII_ZERO | {4'd0, cur_digit};
        byte_d.last = (ptr_q == '0);
      end
      default: begin
        byte_d.data = clcd_pkg::BYTE_CLEAR;
      end
    endcase
  end

  assign byte_valid = (state_q == ST_SEND);
  assign byte_take  = byte_valid && byte_ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take && produces) begin
          state_d = (in_opc == clcd_pkg::OP_INT) ? ST_CONV : ST_SEND;
        end
      end
      ST_CONV: begin
        if (!conv_busy) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros one digit a cycle; at least two digits remain
        if (!((ptr_q > clcd_pkg::PTR_W'(1)) && (cur_digit == '0))) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (byte_take && byte_d.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ptr_q   <= clcd_pkg::PTR_TOP;
    end else begin
      state_q <= state_d;
      if (take) begin
        cnt_q <= '0;
        ptr_q <= clcd_pkg::PTR_TOP;
      end else if (state_q == ST_SKIP && state_d == ST_SKIP) begin
        ptr_q <= ptr_q - 1'b1;
      end else if (byte_take) begin
        cnt_q <= cnt_q + 1'b1;
        ptr_q <= ptr_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      opc_q  <= in_opc;
      row_q  <= in_row;
      col_q  <= in_col;
      char_q <= in_value[7:0];
    end
  end

  clcd_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (byte_valid),
    .byte_ready_o  (byte_ready),
    .byte_i        (byte_d),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
